// ===== design/itaf_pkg.sv =====
// Shared types, codes, constants and the digit-to-character function of the formatter.
`timescale 1ns / 1ps

package itaf_pkg;

  // Conversion codes as they arrive on the input channel.
  localparam logic [1:0] CMD_DEC = 2'd0;
  localparam logic [1:0] CMD_HEX = 2'd1;
  localparam logic [1:0] CMD_OCT = 2'd2;

  localparam int WIDTH_W      = 6;   // field width and character position counters
  localparam int NUM_DIGITS   = 12;  // digit buffer entries
  localparam int DIG_IDX_W    = 4;   // index into the digit buffer
  localparam int DEC_DIGITS   = 10;  // BCD digits for a 32-bit magnitude
  localparam int DABBLE_STEPS = 4;   // shift-and-add-3 steps per clock
  localparam int STEP_W       = 3;   // width of the decimal conversion step counter

  localparam logic [STEP_W-1:0]    STEP_LAST = 3'd7;
  localparam logic [DIG_IDX_W-1:0] DIG_TOP   = 4'd11;

  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;

  typedef enum logic [1:0] {
    FMT_DEC,
    FMT_HEX,
    FMT_OCT
  } fmt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
    logic [5:0]  field_width;
    logic        left_adjust;
    logic        zero_pad;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_item_t;

  // One classified item waiting for the back end.
  typedef struct packed {
    fmt_t               fmt;
    logic               neg;
    logic [31:0]        mag;
    logic [WIDTH_W-1:0] width;
    logic               left_adjust;
    logic               zero_pad;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = 7'h37 + {3'b000, d};
    end
    return c;
  endfunction

endpackage

// ===== design/itaf_front.sv =====
// Front end: accepts input beats, decodes the conversion and forms the magnitude.
`timescale 1ns / 1ps

module itaf_front #(
  parameter int MAX_FIELD_WIDTH = 63
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  itaf_pkg::in_item_t in_data,
  input  itaf_pkg::q_stat_t  q_stat,
  output logic               push,
  output itaf_pkg::job_t     job
);

  logic cmd_ok;

  assign in_stall = q_stat.full;
  // An undefined selector is taken and dropped: it produces no characters.
  assign push = in_valid && !q_stat.full && cmd_ok;

  always_comb begin
    cmd_ok          = 1'b1;
    job.fmt         = itaf_pkg::FMT_DEC;
    job.neg         = 1'b0;
    job.mag         = in_data.value;
    job.left_adjust = in_data.left_adjust;
    job.zero_pad    = in_data.zero_pad;
    if (int'(in_data.field_width) > MAX_FIELD_WIDTH) begin
      job.width = itaf_pkg::WIDTH_W'(MAX_FIELD_WIDTH);
    end else begin
      job.width = in_data.field_width;
    end
    case (in_data.cmd)
      itaf_pkg::CMD_DEC: begin
        job.fmt = itaf_pkg::FMT_DEC;
        job.neg = in_data.value[31];
        // The most negative value negates to itself, which is its correct magnitude.
        if (in_data.value[31]) begin
          job.mag = ~in_data.value + 32'd1;
        end
      end
      itaf_pkg::CMD_HEX: begin
        job.fmt = itaf_pkg::FMT_HEX;
      end
      itaf_pkg::CMD_OCT: begin
        job.fmt = itaf_pkg::FMT_OCT;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/itaf_queue.sv =====
// Two-entry queue of classified items between the front and back ends.
`timescale 1ns / 1ps

module itaf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  itaf_pkg::q_ctl_t  ctl,
  input  itaf_pkg::job_t    wr_job,
  output itaf_pkg::job_t    rd_job,
  output itaf_pkg::q_stat_t stat
);

  itaf_pkg::job_t ent_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign rd_job     = ent_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (ctl.push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (ctl.pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!ctl.push && ctl.pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ent_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ===== design/itaf_back.sv =====
// Back end: converts one item to digits, sizes the text and emits one character per beat.
`timescale 1ns / 1ps

module itaf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  itaf_pkg::q_stat_t   q_stat,
  input  itaf_pkg::job_t      rd_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output itaf_pkg::out_item_t out_data
);

  localparam int DW = itaf_pkg::DIG_IDX_W;
  localparam int WW = itaf_pkg::WIDTH_W;

  itaf_pkg::back_state_t state_r, state_nxt;

  logic           neg_r, neg_nxt;
  logic [WW-1:0]  width_r, width_nxt;
  logic           left_r, left_nxt;
  logic           zpad_r, zpad_nxt;

  logic [itaf_pkg::NUM_DIGITS-1:0][3:0] digs_r, digs_nxt;
  logic [31:0]                          bin_r, bin_nxt;
  logic [itaf_pkg::STEP_W-1:0]          step_r, step_nxt;

  logic [DW-1:0] len_r, len_nxt;
  logic [WW-1:0] extra_r, extra_nxt;
  logic [WW-1:0] total_r, total_nxt;
  logic [WW-1:0] pos_r, pos_nxt;

  logic                out_valid_r, out_valid_nxt;
  itaf_pkg::out_item_t out_data_r, out_data_nxt;

  logic                   out_ready;
  logic [DW-1:0]          ndig;
  logic [DW-1:0]          len_c;
  logic [4*itaf_pkg::DEC_DIGITS+31:0] dab;
  logic                   is_pad;
  logic [WW-1:0]          k;
  logic [DW-1:0]          d;
  logic [6:0]             ch;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_ready = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    width_nxt     = width_r;
    left_nxt      = left_r;
    zpad_nxt      = zpad_r;
    digs_nxt      = digs_r;
    bin_nxt       = bin_r;
    step_nxt      = step_r;
    len_nxt       = len_r;
    extra_nxt     = extra_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    dab           = '0;
    ndig          = 4'd1;
    len_c         = '0;
    is_pad        = 1'b0;
    k             = '0;
    d             = '0;
    ch            = itaf_pkg::CHAR_SPACE;

    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      itaf_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          neg_nxt   = rd_job.neg;
          width_nxt = rd_job.width;
          left_nxt  = rd_job.left_adjust;
          zpad_nxt  = rd_job.zero_pad;
          bin_nxt   = rd_job.mag;
          step_nxt  = '0;
          digs_nxt  = '0;
          case (rd_job.fmt)
            itaf_pkg::FMT_HEX: begin
              for (int i = 0; i < 8; i++) begin
                digs_nxt[i] = rd_job.mag[4*i +: 4];
              end
              state_nxt = itaf_pkg::ST_COUNT;
            end
            itaf_pkg::FMT_OCT: begin
              for (int i = 0; i < 10; i++) begin
                digs_nxt[i] = {1'b0, rd_job.mag[3*i +: 3]};
              end
              digs_nxt[10] = {2'b00, rd_job.mag[31:30]};
              state_nxt    = itaf_pkg::ST_COUNT;
            end
            default: begin
              state_nxt = itaf_pkg::ST_CONV;
            end
          endcase
        end
      end

      itaf_pkg::ST_CONV: begin
        // Double dabble, four bits per clock: add 3 to each BCD digit of 5 or more, then shift.
        dab = {digs_r[itaf_pkg::DEC_DIGITS-1:0], bin_r};
        for (int j = 0; j < itaf_pkg::DABBLE_STEPS; j++) begin
          for (int i = 0; i < itaf_pkg::DEC_DIGITS; i++) begin
            if (dab[32+4*i +: 4] >= 4'd5) begin
              dab[32+4*i +: 4] = dab[32+4*i +: 4] + 4'd3;
            end
          end
          dab = dab << 1;
        end
        digs_nxt[itaf_pkg::DEC_DIGITS-1:0] = dab[4*itaf_pkg::DEC_DIGITS+31:32];
        bin_nxt  = dab[31:0];
        step_nxt = step_r + 3'd1;
        if (step_r == itaf_pkg::STEP_LAST) begin
          state_nxt = itaf_pkg::ST_COUNT;
        end
      end

      itaf_pkg::ST_COUNT: begin
        // Highest nonzero digit sets the count; zero still shows one digit.
        for (int i = 1; i < itaf_pkg::NUM_DIGITS; i++) begin
          if (digs_r[i] != 4'd0) begin
            ndig = DW'(i + 1);
          end
        end
        len_c   = ndig + {3'b000, neg_r};
        len_nxt = len_c;
        if (width_r > {2'b00, len_c}) begin
          extra_nxt = width_r - {2'b00, len_c};
        end else begin
          extra_nxt = '0;
        end
        total_nxt = {2'b00, len_c} + extra_nxt;
        pos_nxt   = '0;
        state_nxt = itaf_pkg::ST_EMIT;
      end

      itaf_pkg::ST_EMIT: begin
        if (left_r) begin
          is_pad = (pos_r >= {2'b00, len_r});
          k      = pos_r;
        end else begin
          is_pad = (pos_r < extra_r);
          k      = pos_r - extra_r;
        end
        d = len_r - 4'd1 - k[DW-1:0];
        if (is_pad) begin
          ch = zpad_r ? itaf_pkg::CHAR_ZERO : itaf_pkg::CHAR_SPACE;
        end else if (neg_r && (k == '0)) begin
          ch = itaf_pkg::CHAR_MINUS;
        end else if (d > itaf_pkg::DIG_TOP) begin
          ch = itaf_pkg::CHAR_ZERO;
        end else begin
          ch = itaf_pkg::digit_char(digs_r[d]);
        end
        if (out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.char_code = ch;
          out_data_nxt.last      = (pos_r == total_r - 6'd1);
          pos_nxt                = pos_r + 6'd1;
          if (pos_r == total_r - 6'd1) begin
            state_nxt = itaf_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = itaf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itaf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    width_r    <= width_nxt;
    left_r     <= left_nxt;
    zpad_r     <= zpad_nxt;
    digs_r     <= digs_nxt;
    bin_r      <= bin_nxt;
    step_r     <= step_nxt;
    len_r      <= len_nxt;
    extra_r    <= extra_nxt;
    total_r    <= total_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== design/integer_to_ascii_formatter_core.sv =====
// Top level of the integer to ASCII formatter: front end, item queue and back end.
`timescale 1ns / 1ps

// Usage: each input beat carries one 32-bit value, a conversion code (signed decimal,
// hexadecimal or octal), a field width and the adjust and pad flags. The block answers
// with one output beat per ASCII character, and marks the final character with last.
// An undefined conversion code is taken and produces no characters at all.
// Flow: the front end classifies the beat and writes it into a two-entry queue, so new
// beats keep coming in while the back end is still busy with an earlier value.
// Sequence: the back end takes one value at a time from the queue; for decimal it first
// runs a double-dabble conversion at four bits per cycle, then it counts the digits and
// emits the characters. The number of characters emitted is the larger of the field
// width and the text length; characters leave at one per cycle while out_stall is low.
// Stalls: while out_stall is high the current beat holds and the back end waits;
// in_stall rises only when both queue entries are taken.
// Reset: a synchronous active-low reset empties the queue, drops any value in progress
// and clears out_valid.

module integer_to_ascii_formatter_core #(
  parameter int MAX_FIELD_WIDTH = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  itaf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output itaf_pkg::out_item_t out_data
);

  itaf_pkg::q_ctl_t  q_ctl;
  itaf_pkg::q_stat_t q_stat;
  itaf_pkg::job_t    wr_job;
  itaf_pkg::job_t    rd_job;
  logic              q_push;
  logic              q_pop;

  assign q_ctl = '{push: q_push, pop: q_pop};

  // Front end decodes the conversion and saturates the field width.
  itaf_front #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (q_push),
    .job      (wr_job)
  );

  // The queue decouples acceptance from character emission.
  itaf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (q_ctl),
    .wr_job (wr_job),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  // Back end converts, sizes the text and streams the characters.
  itaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .rd_job    (rd_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/itaf_checker.sv =====
// Port-level checks of the formatter and the bind that attaches them to the top level.
`timescale 1ns / 1ps

module itaf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input itaf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input itaf_pkg::out_item_t out_data
);

  // A stalled input beat holds its payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Only digits, upper-case hex letters, space and minus are ever emitted.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.char_code >= 7'h30 && out_data.char_code <= 7'h39) ||
                   (out_data.char_code >= 7'h41 && out_data.char_code <= 7'h46) ||
                   out_data.char_code == 7'h20 || out_data.char_code == 7'h2D))
    else $error("illegal character emitted");

  // Reset leaves no output beat pending.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // Reset empties the queue, so input is taken right away.
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("in_stall set after reset");

endmodule

bind integer_to_ascii_formatter_core itaf_checker u_itaf_checker (.*);
